// ===== src/crc8_pkg.sv =====
// Package with the types, register indexes and byte fold function of the CRC-8 stream block.
package crc8_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [ByteW-1:0] TopBit       = 8'h80;
  localparam logic [ByteW-1:0] PolyReset    = 8'h07;
  localparam logic [ByteW-1:0] InitReset    = 8'h00;
  localparam logic [ByteW-1:0] XorOutReset  = 8'h00;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_POLY    = 2'd0,
    CFG_INIT    = 2'd1,
    CFG_XOR_OUT = 2'd2
  } cfg_reg_e;

  // Configuration register set.
  typedef struct packed {
    logic [ByteW-1:0] poly;
    logic [ByteW-1:0] init_value;
    logic [ByteW-1:0] xor_out;
  } cfg_t;

  // XOR one byte into the register, then shift eight times MSB first.
  function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] start,
                                                 input logic [ByteW-1:0] in_byte,
                                                 input logic [ByteW-1:0] gen);
    logic [ByteW-1:0] acc;
    acc = start ^ in_byte;
    for (int k = 0; k < ByteW; k++) begin
      if ((acc & TopBit) != '0) begin
        acc = {acc[ByteW-2:0], 1'b0} ^ gen;
      end else begin
        acc = {acc[ByteW-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

// ===== src/crc8_core.sv =====
// Running CRC register and message start flag, updated once per consumed byte.
module crc8_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [crc8_pkg::ByteW-1:0] data_i,
  input  logic                       last_i,
  input  crc8_pkg::cfg_t             cfg_i,
  output logic [crc8_pkg::ByteW-1:0] result_o
);

  logic [crc8_pkg::ByteW-1:0] crc_q, crc_d;
  logic                       at_start_q, at_start_d;
  logic [crc8_pkg::ByteW-1:0] base;

  // A message starts from the initial value, otherwise from the running register.
  always_comb begin
    base       = at_start_q ? cfg_i.init_value : crc_q;
    crc_d      = crc8_pkg::fold_byte(base, data_i, cfg_i.poly);
    at_start_d = last_i;
    result_o   = crc_d ^ cfg_i.xor_out;
  end

  // State update on each consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= '0;
      at_start_q <= 1'b1;
    end else if (en_i) begin
      crc_q      <= crc_d;
      at_start_q <= at_start_d;
    end
  end

endmodule

// ===== src/crc8_msb_first_stream.sv =====
// Top level of the streaming MSB-first CRC-8 with configurable polynomial, init and xorout.
//
//  channel   direction  payload                              request taken when
//  s_axis    in         tdata[7:0]=data_byte, tlast=last     s_axis_tvalid_i & s_axis_tready_o
//  m_axis    out        tdata[7:0]=crc_value                 m_axis_tvalid_o & m_axis_tready_i
//  cfg       in         cfg_addr_i=index, cfg_wdata_i=value  cfg_valid_i & cfg_ready_o
//
// One byte per cycle unless a last byte waits on a stalled output: a byte is registered,
// folded combinationally by the eight unrolled XOR-shift steps of the core, and a
// finished CRC lands in the output register. The result of a last byte passes the
// input stage and then the output register before it shows on m_axis.
// Reset restores poly 0x07, init 0x00, xorout 0x00 and arms a new message.
// A stalled output only holds the input stage when the byte waiting there is a last byte.
module crc8_msb_first_stream (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // s_axis_tdata_i: [7:0] data_byte
  input  logic [crc8_pkg::ByteW-1:0]    s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // m_axis_tdata_o: [7:0] crc_value
  output logic [crc8_pkg::ByteW-1:0]    m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [crc8_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [crc8_pkg::ByteW-1:0]    cfg_wdata_i
);

  crc8_pkg::cfg_t             cfg_q;
  logic                       in_valid_q;
  logic [crc8_pkg::ByteW-1:0] in_data_q;
  logic                       in_last_q;
  logic                       out_valid_q;
  logic [crc8_pkg::ByteW-1:0] out_data_q;
  logic [crc8_pkg::ByteW-1:0] result;
  logic                       in_fire;
  logic                       out_load;
  logic                       s_accept;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly       <= crc8_pkg::PolyReset;
      cfg_q.init_value <= crc8_pkg::InitReset;
      cfg_q.xor_out    <= crc8_pkg::XorOutReset;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        crc8_pkg::CFG_POLY:    cfg_q.poly       <= cfg_wdata_i;
        crc8_pkg::CFG_INIT:    cfg_q.init_value <= cfg_wdata_i;
        crc8_pkg::CFG_XOR_OUT: cfg_q.xor_out    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The input stage moves on unless a last byte meets a full, stalled output register.
  always_comb begin
    in_fire         = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
    out_load        = in_fire && in_last_q;
    s_axis_tready_o = !in_valid_q || in_fire;
    s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  end

  // Input stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  crc8_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_fire),
    .data_i   (in_data_q),
    .last_i   (in_last_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== dv/crc8_msb_first_stream_tb.sv =====
// Self-checking testbench for the streaming MSB-first CRC-8 block with configurable registers.
`timescale 1ns / 1ps

module crc8_msb_first_stream_tb;

  typedef logic [crc8_pkg::ByteW-1:0] byte_t;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomItems  = 480;
  localparam longint      TimeoutNs    = 1_000_000;

  // Index past the last register; writes to it must be ignored.
  localparam logic [crc8_pkg::CfgAddrW-1:0] CfgUnused = 2'd3;

  // Polynomials commonly offered for this CRC.
  localparam byte_t PolyCrc8    = 8'h07;
  localparam byte_t PolyCrc8Alt = 8'h31;
  localparam byte_t AllOnes     = 8'hff;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  byte_t                         s_tdata = '0;
  logic                          s_tlast = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_axis_tready_o;
  byte_t                         m_axis_tdata_o;
  logic                          m_axis_tvalid_o;
  logic                          m_tready = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready_o;
  logic [crc8_pkg::CfgAddrW-1:0] cfg_addr = '0;
  byte_t                         cfg_wdata = '0;

  // Mirror of the block: its registers and running CRC state.
  crc8_pkg::cfg_t cfg_shadow;
  byte_t          running_crc;
  logic           msg_first;
  byte_t          pending_crcs[$];

  int  mismatch_count = 0;
  int  stall_left = 0;
  // When set, neither side idles.
  logic steady = 1'b0;

  crc8_msb_first_stream DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  // Free-running clock with a 2 ns period.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shift one byte through the CRC register, top bit first.
  function automatic byte_t fold_msb_first(input byte_t seed, input byte_t data,
                                           input byte_t gen);
    byte_t acc;
    logic  msb;
    acc = seed ^ data;
    repeat (crc8_pkg::ByteW) begin
      msb = acc[crc8_pkg::ByteW-1];
      acc = acc << 1;
      if (msb) begin
        acc = acc ^ gen;
      end
    end
    return acc;
  endfunction

  // Update the mirror with an accepted byte and queue the CRC it finishes.
  function automatic void predict_byte(input byte_t value, input logic last);
    running_crc = fold_msb_first(msg_first ? cfg_shadow.init_value : running_crc,
                                 value, cfg_shadow.poly);
    if (last) begin
      pending_crcs.push_back(running_crc ^ cfg_shadow.xor_out);
    end
    msg_first = last;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  // Message length: mostly short, a few long ones.
  function automatic int pick_msg_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 4);
    end else if (r < 90) begin
      return $urandom_range(5, 16);
    end
    return $urandom_range(17, 64);
  endfunction

  // Send one byte request and wait until the block takes it.
  task automatic send_byte(input byte_t value, input logic last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= value;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    predict_byte(value, last);
  endtask

  // Stop sending, wait for every queued CRC, then let the pipeline empty.
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (pending_crcs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Issue one register write request; only called while the block is idle.
  task automatic write_reg(input logic [crc8_pkg::CfgAddrW-1:0] addr, input byte_t value);
    cfg_addr  <= addr;
    cfg_wdata <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (addr)
      crc8_pkg::CFG_POLY:    cfg_shadow.poly = value;
      crc8_pkg::CFG_INIT:    cfg_shadow.init_value = value;
      crc8_pkg::CFG_XOR_OUT: cfg_shadow.xor_out = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: check each accepted CRC, then pick the next ready level.
  always @(posedge clk_i) begin
    int r;
    byte_t want;
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_tready) begin
      if (pending_crcs.size() == 0) begin
        $error("crc_value: no result expected, actual %02h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = pending_crcs.pop_front();
        if (m_axis_tdata_o !== want) begin
          $error("crc_value: expected %02h, actual %02h", want, m_axis_tdata_o);
          mismatch_count++;
        end
      end
    end
    if (steady) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_tready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
        m_tready <= 1'b0;
      end
    end
  end

  // Reset values: extreme bytes and short messages.
  task automatic test_reset_config();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    drain_block();
  endtask

  // Extreme register settings, including an ignored write to an unused index.
  task automatic test_config_extremes();
    write_reg(crc8_pkg::CFG_POLY, PolyCrc8Alt);
    write_reg(crc8_pkg::CFG_INIT, AllOnes);
    write_reg(crc8_pkg::CFG_XOR_OUT, AllOnes);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h31, 1'b0);
    send_byte(8'h32, 1'b0);
    send_byte(8'h33, 1'b1);
    drain_block();
    write_reg(crc8_pkg::CFG_POLY, 8'h00);
    write_reg(crc8_pkg::CFG_INIT, 8'h00);
    send_byte(8'ha5, 1'b1);
    drain_block();
    write_reg(crc8_pkg::CFG_POLY, AllOnes);
    write_reg(crc8_pkg::CFG_INIT, 8'h55);
    write_reg(crc8_pkg::CFG_XOR_OUT, 8'h00);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_block();
    write_reg(CfgUnused, 8'h5a);
    send_byte(8'hc3, 1'b1);
    drain_block();
  endtask

  // Writes while a message is open: init waits for the next message.
  task automatic test_write_mid_message();
    write_reg(crc8_pkg::CFG_POLY, PolyCrc8);
    write_reg(crc8_pkg::CFG_INIT, 8'h00);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    drain_block();
    write_reg(crc8_pkg::CFG_POLY, PolyCrc8Alt);
    write_reg(crc8_pkg::CFG_INIT, AllOnes);
    write_reg(crc8_pkg::CFG_XOR_OUT, AllOnes);
    send_byte(8'h56, 1'b1);
    send_byte(8'h00, 1'b1);
    drain_block();
  endtask

  // Pick a fresh register setting for one phase of random traffic.
  task automatic randomize_config();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      write_reg(crc8_pkg::CFG_POLY, $urandom_range(0, 1) ? PolyCrc8 : PolyCrc8Alt);
    end else if (r < 80) begin
      write_reg(crc8_pkg::CFG_POLY, byte_t'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      write_reg(crc8_pkg::CFG_INIT, $urandom_range(0, 1) ? AllOnes : 8'h00);
    end else if (r < 80) begin
      write_reg(crc8_pkg::CFG_INIT, byte_t'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      write_reg(crc8_pkg::CFG_XOR_OUT, $urandom_range(0, 1) ? AllOnes : 8'h00);
    end else if (r < 80) begin
      write_reg(crc8_pkg::CFG_XOR_OUT, byte_t'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) begin
      write_reg(CfgUnused, byte_t'($urandom_range(0, 255)));
    end
  endtask

  // Random messages in phases, with new settings between phases.
  task automatic test_random_traffic();
    int sent;
    int msg_left;
    int phase_len;
    sent = 0;
    msg_left = 0;
    while (sent < RandomItems) begin
      randomize_config();
      steady = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(10, 60);
      for (int i = 0; i < phase_len; i++) begin
        if (msg_left == 0) begin
          msg_left = pick_msg_len();
        end
        msg_left--;
        send_byte(byte_t'($urandom_range(0, 255)), msg_left == 0);
        sent++;
      end
      drain_block();
    end
    steady = 1'b0;
    if (msg_left != 0) begin
      send_byte(byte_t'($urandom_range(0, 255)), 1'b1);
    end
    drain_block();
  endtask

  // Main sequence: reset once, run each test, report.
  initial begin
    cfg_shadow.poly       = crc8_pkg::PolyReset;
    cfg_shadow.init_value = crc8_pkg::InitReset;
    cfg_shadow.xor_out    = crc8_pkg::XorOutReset;
    running_crc = '0;
    msg_first   = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_config();
    test_config_extremes();
    test_write_mid_message();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("crc8_msb_first_stream_tb passed");
    end else begin
      $display("crc8_msb_first_stream_tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TimeoutNs);
    $display("crc8_msb_first_stream_tb failed");
    $finish;
  end

endmodule
